### rtl/core/cbp_pkg.sv
// shared types and constants for the circle versus box push-out pipeline
// no dependencies; used by cbp_isqrt, cbp_div2 and circle_box_push_out
package cbp_pkg;

  localparam int CW = 24;          // coordinate width, signed Q15.8
  localparam int K  = CW - 1;      // root, push and quotient width
  localparam int NB = 2 * K;       // radicand and dividend width

  typedef struct packed {
    logic signed [CW-1:0] center_x;
    logic signed [CW-1:0] center_y;
    logic        [CW-2:0] radius;
    logic signed [CW-1:0] box_min_x;
    logic signed [CW-1:0] box_min_y;
    logic signed [CW-1:0] box_max_x;
    logic signed [CW-1:0] box_max_y;
  } in_word_t;

  typedef struct packed {
    logic                 hit;
    logic signed [CW-1:0] push_x;
    logic signed [CW-1:0] push_y;
  } out_word_t;

  typedef enum logic [1:0] {
    FACE_LEFT,
    FACE_RIGHT,
    FACE_BOTTOM,
    FACE_TOP
  } face_t;

  // fields carried alongside the square root
  typedef struct packed {
    logic         hit;
    logic         in_box;
    logic         neg_x;
    logic         neg_y;
    logic [K-1:0] ax;
    logic [K-1:0] ay;
    logic [K-1:0] r;
    logic [CW:0]  mag;
    face_t        face;
  } sq_side_t;

  // fields carried alongside the division
  typedef struct packed {
    logic        hit;
    logic        in_box;
    logic        neg_x;
    logic        neg_y;
    logic [CW:0] mag;
    face_t       face;
  } dv_side_t;

endpackage

### rtl/core/cbp_isqrt.sv
// pipelined integer square root, one result bit per stage
// depends on cbp_pkg
module cbp_isqrt (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      en,
  input  logic                      in_valid,
  input  logic [cbp_pkg::NB-1:0]    in_data,
  input  cbp_pkg::sq_side_t         in_side,
  output logic                      out_valid,
  output logic [cbp_pkg::K-1:0]     out_root,
  output cbp_pkg::sq_side_t         out_side
);

  localparam int K  = cbp_pkg::K;
  localparam int NB = cbp_pkg::NB;
  localparam int RW = K + 2;

  logic                   v_a    [0:K];
  logic [RW-1:0]          rem_a  [0:K];
  logic [K-1:0]           root_a [0:K];
  logic [NB-1:0]          n_a    [0:K];
  cbp_pkg::sq_side_t      side_a [0:K];

  assign v_a[0]    = in_valid;
  assign rem_a[0]  = '0;
  assign root_a[0] = '0;
  assign n_a[0]    = in_data;
  assign side_a[0] = in_side;

  for (genvar s = 0; s < K; s++) begin : g_stage
    logic [RW-1:0] rem_sh;
    logic [RW-1:0] trial;
    logic          ge;

    // remainder never reaches the two dropped bits
    assign rem_sh = {rem_a[s][RW-3:0], n_a[s][NB-1 -: 2]};
    assign trial  = {root_a[s], 2'b01};
    assign ge     = (rem_sh >= trial);

    always_ff @(posedge clk) begin
      if (rst) begin
        v_a[s+1] <= 1'b0;
      end else if (en) begin
        v_a[s+1] <= v_a[s];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_a[s+1]  <= ge ? (rem_sh - trial) : rem_sh;
        root_a[s+1] <= {root_a[s][K-2:0], ge};
        n_a[s+1]    <= n_a[s] << 2;
        side_a[s+1] <= side_a[s];
      end
    end
  end

  assign out_valid = v_a[K];
  assign out_root  = root_a[K];
  assign out_side  = side_a[K];

endmodule

### rtl/core/cbp_div2.sv
// pipelined restoring divider, two dividends over one shared divisor
// depends on cbp_pkg; quotient must fit K bits
module cbp_div2 (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      en,
  input  logic                      in_valid,
  input  logic [cbp_pkg::NB-1:0]    num_x,
  input  logic [cbp_pkg::NB-1:0]    num_y,
  input  logic [cbp_pkg::K-1:0]     den,
  input  cbp_pkg::dv_side_t         in_side,
  output logic                      out_valid,
  output logic [cbp_pkg::K-1:0]     quo_x,
  output logic [cbp_pkg::K-1:0]     quo_y,
  output cbp_pkg::dv_side_t         out_side
);

  localparam int K = cbp_pkg::K;

  logic                v_a    [0:K];
  logic [K-1:0]        den_a  [0:K];
  logic [K-1:0]        rem_a  [0:K][0:1];
  logic [K-1:0]        lo_a   [0:K][0:1];
  logic [K-1:0]        q_a    [0:K][0:1];
  cbp_pkg::dv_side_t   side_a [0:K];

  assign v_a[0]     = in_valid;
  assign den_a[0]   = den;
  assign side_a[0]  = in_side;
  assign rem_a[0][0] = num_x[2*K-1:K];
  assign lo_a[0][0]  = num_x[K-1:0];
  assign q_a[0][0]   = '0;
  assign rem_a[0][1] = num_y[2*K-1:K];
  assign lo_a[0][1]  = num_y[K-1:0];
  assign q_a[0][1]   = '0;

  for (genvar s = 0; s < K; s++) begin : g_stage
    always_ff @(posedge clk) begin
      if (rst) begin
        v_a[s+1] <= 1'b0;
      end else if (en) begin
        v_a[s+1] <= v_a[s];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        den_a[s+1]  <= den_a[s];
        side_a[s+1] <= side_a[s];
      end
    end

    for (genvar l = 0; l < 2; l++) begin : g_lane
      logic [K:0] rem_sh;
      logic [K:0] diff;
      logic       ge;

      assign rem_sh = {rem_a[s][l], lo_a[s][l][K-1]};
      assign diff   = rem_sh - {1'b0, den_a[s]};
      assign ge     = (rem_sh >= {1'b0, den_a[s]});

      always_ff @(posedge clk) begin
        if (en) begin
          rem_a[s+1][l] <= ge ? diff[K-1:0] : rem_sh[K-1:0];
          lo_a[s+1][l]  <= lo_a[s][l] << 1;
          q_a[s+1][l]   <= {q_a[s][l][K-2:0], ge};
        end
      end
    end
  end

  assign out_valid = v_a[K];
  assign quo_x     = q_a[K][0];
  assign quo_y     = q_a[K][1];
  assign out_side  = side_a[K];

endmodule

### rtl/core/circle_box_push_out.sv
// circle versus axis-aligned box overlap with push-out vector, top level
// depends on cbp_pkg, cbp_isqrt and cbp_div2
// the K-stage square root and the K-stage divider each give one result bit per stage
// throughput: one word per cycle; the whole pipeline holds while a result waits
// reset: synchronous rst clears every stage valid bit, payload is not reset
module circle_box_push_out (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  cbp_pkg::in_word_t   in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output cbp_pkg::out_word_t  out_data
);

  localparam int CW = cbp_pkg::CW;
  localparam int K  = cbp_pkg::K;
  localparam int NB = cbp_pkg::NB;

  localparam logic [CW:0]   POS_LIM = {2'b00, {(CW-1){1'b1}}};
  localparam logic [CW:0]   NEG_LIM = {2'b01, {(CW-1){1'b0}}};
  localparam logic [CW-1:0] SAT_MAX = {1'b0, {(CW-1){1'b1}}};
  localparam logic [CW-1:0] SAT_MIN = {1'b1, {(CW-1){1'b0}}};

  logic en;
  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  // stage a: clamp and offsets
  logic signed [CW-1:0] near_x, near_y;
  logic signed [CW:0]   dx, dy;

  always_comb begin
    if (in_data.center_x < in_data.box_min_x)      near_x = in_data.box_min_x;
    else if (in_data.center_x > in_data.box_max_x) near_x = in_data.box_max_x;
    else                                           near_x = in_data.center_x;
    if (in_data.center_y < in_data.box_min_y)      near_y = in_data.box_min_y;
    else if (in_data.center_y > in_data.box_max_y) near_y = in_data.box_max_y;
    else                                           near_y = in_data.center_y;
    dx = (CW+1)'(in_data.center_x) - (CW+1)'(near_x);
    dy = (CW+1)'(in_data.center_y) - (CW+1)'(near_y);
  end

  logic                 a_v;
  logic [CW-1:0]        a_ax, a_ay;
  logic                 a_neg_x, a_neg_y;
  logic signed [CW:0]   a_left, a_right, a_bottom, a_top;
  logic [K-1:0]         a_r;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_v <= 1'b0;
    end else if (en) begin
      a_v <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_neg_x  <= dx[CW];
      a_neg_y  <= dy[CW];
      a_ax     <= dx[CW] ? CW'(-dx) : dx[CW-1:0];
      a_ay     <= dy[CW] ? CW'(-dy) : dy[CW-1:0];
      a_left   <= (CW+1)'(in_data.center_x) - (CW+1)'(in_data.box_min_x);
      a_right  <= (CW+1)'(in_data.box_max_x) - (CW+1)'(in_data.center_x);
      a_bottom <= (CW+1)'(in_data.center_y) - (CW+1)'(in_data.box_min_y);
      a_top    <= (CW+1)'(in_data.box_max_y) - (CW+1)'(in_data.center_y);
      a_r      <= in_data.radius;
    end
  end

  // stage b: squares and nearest face, strict less-than keeps earlier face
  logic signed [CW:0] best;
  cbp_pkg::face_t     face;

  always_comb begin
    best = a_left;
    face = cbp_pkg::FACE_LEFT;
    if (a_right < best) begin
      best = a_right;
      face = cbp_pkg::FACE_RIGHT;
    end
    if (a_bottom < best) begin
      best = a_bottom;
      face = cbp_pkg::FACE_BOTTOM;
    end
    if (a_top < best) begin
      best = a_top;
      face = cbp_pkg::FACE_TOP;
    end
  end

  logic               b_v;
  logic [2*CW-1:0]    b_axsq, b_aysq;
  logic [NB-1:0]      b_rsq;
  logic signed [CW:0] b_best;
  cbp_pkg::face_t     b_face;
  logic               b_neg_x, b_neg_y;
  logic [K-1:0]       b_ax, b_ay, b_r;

  always_ff @(posedge clk) begin
    if (rst) begin
      b_v <= 1'b0;
    end else if (en) begin
      b_v <= a_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b_axsq  <= a_ax * a_ax;
      b_aysq  <= a_ay * a_ay;
      b_rsq   <= a_r * a_r;
      b_best  <= best;
      b_face  <= face;
      b_neg_x <= a_neg_x;
      b_neg_y <= a_neg_y;
      b_ax    <= a_ax[K-1:0];
      b_ay    <= a_ay[K-1:0];
      b_r     <= a_r;
    end
  end

  // stage c: squared distance, hit test, inside length
  logic [2*CW:0] dist_sq;
  assign dist_sq = {1'b0, b_axsq} + {1'b0, b_aysq};

  logic              c_v;
  logic [NB-1:0]     c_dsq;
  cbp_pkg::sq_side_t c_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      c_v <= 1'b0;
    end else if (en) begin
      c_v <= b_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // on a hit the squared distance fits the radicand width
      c_dsq         <= dist_sq[NB-1:0];
      c_side.hit    <= dist_sq < (2*CW+1)'(b_rsq);
      c_side.in_box <= (dist_sq == '0);
      c_side.neg_x  <= b_neg_x;
      c_side.neg_y  <= b_neg_y;
      c_side.ax     <= b_ax;
      c_side.ay     <= b_ay;
      c_side.r      <= b_r;
      c_side.mag    <= (CW+1)'(b_r) + b_best;
      c_side.face   <= b_face;
    end
  end

  logic              s_v;
  logic [K-1:0]      s_dist;
  cbp_pkg::sq_side_t s_side;

  cbp_isqrt u_isqrt (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (c_v),
    .in_data  (c_dsq),
    .in_side  (c_side),
    .out_valid(s_v),
    .out_root (s_dist),
    .out_side (s_side)
  );

  // stage d: push length and scaled offsets
  logic [K-1:0] push_len;
  assign push_len = s_side.r - s_dist;

  logic              d_v;
  logic [NB-1:0]     d_num_x, d_num_y;
  logic [K-1:0]      d_dist;
  logic [K-1:0]      d_r;
  cbp_pkg::dv_side_t d_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      d_v <= 1'b0;
    end else if (en) begin
      d_v <= s_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_num_x       <= s_side.ax * push_len;
      d_num_y       <= s_side.ay * push_len;
      d_dist        <= s_dist;
      d_r           <= s_side.r;
      d_side.hit    <= s_side.hit;
      d_side.in_box <= s_side.in_box;
      d_side.neg_x  <= s_side.neg_x;
      d_side.neg_y  <= s_side.neg_y;
      d_side.mag    <= s_side.mag;
      d_side.face   <= s_side.face;
    end
  end

  logic              q_v;
  logic [K-1:0]      q_x, q_y;
  cbp_pkg::dv_side_t q_side;

  cbp_div2 u_div2 (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (d_v),
    .num_x    (d_num_x),
    .num_y    (d_num_y),
    .den      (d_dist),
    .in_side  (d_side),
    .out_valid(q_v),
    .quo_x    (q_x),
    .quo_y    (q_y),
    .out_side (q_side)
  );

  // final stage: sign, face select, saturation
  logic [CW-1:0] mag_pos, mag_neg, vx, vy;
  cbp_pkg::out_word_t res;

  always_comb begin
    mag_pos = (q_side.mag > POS_LIM) ? SAT_MAX : q_side.mag[CW-1:0];
    mag_neg = (q_side.mag > NEG_LIM) ? SAT_MIN : CW'(-q_side.mag);
    vx = {1'b0, q_x};
    vy = {1'b0, q_y};
    res = '0;
    if (q_side.hit) begin
      res.hit = 1'b1;
      if (q_side.in_box) begin
        case (q_side.face)
          cbp_pkg::FACE_LEFT:   res.push_x = mag_neg;
          cbp_pkg::FACE_RIGHT:  res.push_x = mag_pos;
          cbp_pkg::FACE_BOTTOM: res.push_y = mag_neg;
          default:              res.push_y = mag_pos;
        endcase
      end else begin
        res.push_x = q_side.neg_x ? -vx : vx;
        res.push_y = q_side.neg_y ? -vy : vy;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= q_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data <= res;
    end
  end

  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_data.hit) |-> (out_data.push_x == '0 && out_data.push_y == '0))
    else $error("miss word carries a nonzero push");

  a_root_below_radius: assert property (@(posedge clk) disable iff (rst)
    (d_v && d_side.hit) |-> (d_dist < d_r))
    else $error("square root not below radius on a hit");

  a_outside_nonzero_root: assert property (@(posedge clk) disable iff (rst)
    (d_v && d_side.hit && !d_side.in_box) |-> (d_dist != '0))
    else $error("zero divisor for an outside hit");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    (!en && c_v) |=> c_v)
    else $error("pipeline word lost during stall");

endmodule

### tb/sv/circle_box_push_out_tb.sv
`timescale 1ns / 1ps
// testbench for circle_box_push_out: directed table then random words,
// checked against a predictor of the overlap and push-out math; needs cbp_pkg
module circle_box_push_out_tb;

  localparam int CW = cbp_pkg::CW;
  localparam int K  = cbp_pkg::K;
  localparam int LAT = 2 * K + 5;
  localparam int N_RANDOM = 1930;
  localparam longint CYCLE_LIMIT = 400000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  cbp_pkg::in_word_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  cbp_pkg::out_word_t out_data;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  circle_box_push_out dut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .in_data(in_data), .out_valid(out_valid), .out_ready(out_ready),
    .out_data(out_data)
  );

  cbp_pkg::out_word_t pending_push[$];
  int mismatches = 0;
  longint cycles = 0;
  bit stim_done = 1'b0;

  function automatic longint clamp_to(longint v, longint lo, longint hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic longint root_floor(longint n);
    longint res, bit_v;
    res = 0;
    bit_v = longint'(1) << 62;
    while (bit_v > n) bit_v >>= 2;
    while (bit_v != 0) begin
      if (n >= res + bit_v) begin
        n -= res + bit_v;
        res = (res >> 1) + bit_v;
      end else res >>= 1;
      bit_v >>= 2;
    end
    return res;
  endfunction

  function automatic logic signed [CW-1:0] sat_coord(longint v);
    longint hi, lo;
    hi = (longint'(1) << (CW - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) v = hi;
    if (v < lo) v = lo;
    return v[CW-1:0];
  endfunction

  function automatic longint scale_along(longint d, longint push, longint den_v);
    longint q;
    q = ((d < 0 ? -d : d) * push) / den_v;
    return d < 0 ? -q : q;
  endfunction

  function automatic cbp_pkg::out_word_t predict_push(cbp_pkg::in_word_t w);
    cbp_pkg::out_word_t o;
    longint cx, cy, r, mnx, mny, mxx, mxy, dx, dy, dsq, root_v, px, py, best, m;
    cbp_pkg::face_t face;
    cx = w.center_x; cy = w.center_y; r = w.radius;
    mnx = w.box_min_x; mny = w.box_min_y; mxx = w.box_max_x; mxy = w.box_max_y;
    dx = cx - clamp_to(cx, mnx, mxx);
    dy = cy - clamp_to(cy, mny, mxy);
    dsq = dx * dx + dy * dy;
    o = '0;
    if (dsq >= r * r) return o;
    px = 0; py = 0;
    if (dsq != 0) begin
      root_v = root_floor(dsq);
      px = scale_along(dx, r - root_v, root_v);
      py = scale_along(dy, r - root_v, root_v);
    end else begin
      best = cx - mnx; face = cbp_pkg::FACE_LEFT;
      if (mxx - cx < best) begin best = mxx - cx; face = cbp_pkg::FACE_RIGHT; end
      if (cy - mny < best) begin best = cy - mny; face = cbp_pkg::FACE_BOTTOM; end
      if (mxy - cy < best) begin best = mxy - cy; face = cbp_pkg::FACE_TOP; end
      m = r + best;
      case (face)
        cbp_pkg::FACE_LEFT: px = -m;
        cbp_pkg::FACE_RIGHT: px = m;
        cbp_pkg::FACE_BOTTOM: py = -m;
        default: py = m;
      endcase
    end
    o.hit = 1'b1;
    o.push_x = sat_coord(px);
    o.push_y = sat_coord(py);
    return o;
  endfunction

  function automatic cbp_pkg::in_word_t mk(int cx, int cy, int r, int ax, int ay,
                                           int bx, int by);
    cbp_pkg::in_word_t w;
    w.center_x = CW'(cx); w.center_y = CW'(cy); w.radius = (CW-1)'(r);
    w.box_min_x = CW'(ax); w.box_min_y = CW'(ay);
    w.box_max_x = CW'(bx); w.box_max_y = CW'(by);
    return w;
  endfunction

  function automatic logic signed [CW-1:0] rnd_coord();
    case ($urandom_range(0, 3))
      0: return CW'($urandom);
      1: return CW'($signed($urandom_range(0, 8191)) - 4096);
      2: return CW'(($urandom_range(0, 1) ? 24'sh7fffff : 24'sh800000)
                    - $signed($urandom_range(0, 3)));
      default: return CW'($signed($urandom_range(0, 262143)) - 131072);
    endcase
  endfunction

  function automatic cbp_pkg::in_word_t rnd_word();
    cbp_pkg::in_word_t w;
    int lo_x, lo_y;
    w.radius = (CW-1)'($urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 20000));
    if ($urandom_range(0, 4) == 0) begin
      w.center_x = rnd_coord(); w.center_y = rnd_coord();
      w.box_min_x = rnd_coord(); w.box_min_y = rnd_coord();
      w.box_max_x = rnd_coord(); w.box_max_y = rnd_coord();
    end else begin
      // box near the circle so hits are common
      lo_x = $signed($urandom_range(0, 40000)) - 20000;
      lo_y = $signed($urandom_range(0, 40000)) - 20000;
      w.box_min_x = CW'(lo_x); w.box_min_y = CW'(lo_y);
      w.box_max_x = CW'(lo_x + $urandom_range(0, 10000));
      w.box_max_y = CW'(lo_y + $urandom_range(0, 10000));
      w.center_x = CW'(lo_x + $signed($urandom_range(0, 30000)) - 10000);
      w.center_y = CW'(lo_y + $signed($urandom_range(0, 30000)) - 10000);
    end
    return w;
  endfunction

  // valid stays high into a zero gap, so only one drive per edge
  task automatic send_word(cbp_pkg::in_word_t w);
    int gap;
    gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 18);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= w;
    do @(posedge clk); while (!in_ready);
    pending_push.push_back(predict_push(w));
  endtask

  // directed rows: known result typed in where obvious, else predictor
  typedef struct {
    cbp_pkg::in_word_t w;
    bit known;
    cbp_pkg::out_word_t res;
  } row_t;

  initial begin
    row_t rows[$];
    row_t rw;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // far miss, zero radius, max radius
    rw.w = mk(1000, 1000, 10, 0, 0, 100, 100); rw.known = 1; rw.res = '0; rows.push_back(rw);
    rw.w = mk(50, 50, 0, 0, 0, 100, 100); rw.known = 1; rw.res = '0; rows.push_back(rw);
    rw.w = mk(-8388608, -8388608, 8388607, 8388607, 8388607, 8388607, 8388607);
    rw.known = 0; rows.push_back(rw);
    rw.w = mk(8388607, 8388607, 8388607, -8388608, -8388608, -8388608, -8388608);
    rw.known = 0; rows.push_back(rw);
    rw.w = mk(0, 0, 8388607, -8388608, -8388608, 8388607, 8388607);
    rw.known = 0; rows.push_back(rw);
    // inside: each face and ties
    rw.w = mk(10, 50, 5, 0, 0, 100, 100); rw.known = 1;
    rw.res = '{1'b1, -24'sd15, 24'sd0}; rows.push_back(rw);
    rw.w = mk(90, 50, 5, 0, 0, 100, 100); rw.known = 1;
    rw.res = '{1'b1, 24'sd15, 24'sd0}; rows.push_back(rw);
    rw.w = mk(50, 10, 5, 0, 0, 100, 100); rw.known = 1;
    rw.res = '{1'b1, 24'sd0, -24'sd15}; rows.push_back(rw);
    rw.w = mk(50, 90, 5, 0, 0, 100, 100); rw.known = 1;
    rw.res = '{1'b1, 24'sd0, 24'sd15}; rows.push_back(rw);
    rw.w = mk(50, 50, 5, 0, 0, 100, 100); rw.known = 1;
    rw.res = '{1'b1, -24'sd55, 24'sd0}; rows.push_back(rw);
    rw.w = mk(100, 0, 5, 0, 0, 100, 100); rw.known = 1;
    rw.res = '{1'b1, 24'sd5, 24'sd0}; rows.push_back(rw);
    rw.w = mk(0, 0, 1, 0, 0, 0, 0); rw.known = 1;
    rw.res = '{1'b1, -24'sd1, 24'sd0}; rows.push_back(rw);
    // outside hits, corner, exact touch, inverted box
    rw.w = mk(110, 50, 20, 0, 0, 100, 100); rw.known = 1;
    rw.res = '{1'b1, 24'sd10, 24'sd0}; rows.push_back(rw);
    rw.w = mk(50, -7, 20, 0, 0, 100, 100); rw.known = 1;
    rw.res = '{1'b1, 24'sd0, -24'sd13}; rows.push_back(rw);
    rw.w = mk(120, 50, 20, 0, 0, 100, 100); rw.known = 1; rw.res = '0; rows.push_back(rw);
    rw.w = mk(103, 104, 20, 0, 0, 100, 100); rw.known = 0; rows.push_back(rw);
    rw.w = mk(-3, -4, 7, 0, 0, 100, 100); rw.known = 0; rows.push_back(rw);
    rw.w = mk(50, 50, 300, 100, 100, 0, 0); rw.known = 0; rows.push_back(rw);
    rw.w = mk(150, 50, 300, 100, 100, 0, 0); rw.known = 0; rows.push_back(rw);
    rw.w = mk(-1, -1, 8388607, -8388608, -8388608, -2, -2); rw.known = 0; rows.push_back(rw);
    foreach (rows[i]) begin
      if (rows[i].known && predict_push(rows[i].w) != rows[i].res)
        $display("table row %0d disagrees with predictor", i);
      send_word(rows[i].w);
      if (rows[i].known) pending_push[$] = rows[i].res;
    end
    for (int n = 0; n < N_RANDOM; n++) begin
      if (n == N_RANDOM / 2) begin
        in_valid <= 1'b0;
        wait (pending_push.size() == 0);
      end
      send_word(rnd_word());
    end
    in_valid <= 1'b0;
    stim_done = 1'b1;
  end

  // receiver: random stalls, with stretches of none
  initial begin
    int stall;
    int calm;
    calm = 0;
    @(posedge clk);
    forever begin
      if (calm > 0) begin
        calm--; stall = 0;
      end else if ($urandom_range(0, 60) == 0) begin
        calm = $urandom_range(20, 80); stall = 0;
      end else stall = $urandom_range(0, 18);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  always @(posedge clk) begin
    cbp_pkg::out_word_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_push.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected word %p", out_data);
      end else begin
        want = pending_push.pop_front();
        if (out_data.hit !== want.hit || out_data.push_x !== want.push_x
            || out_data.push_y !== want.push_y) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected hit=%0b x=%0d y=%0d, got hit=%0b x=%0d y=%0d",
                     want.hit, want.push_x, want.push_y,
                     out_data.hit, out_data.push_x, out_data.push_y);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    wait (stim_done);
    wait (pending_push.size() == 0);
    repeat (LAT + 20) @(posedge clk);
    if (mismatches == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

endmodule
